// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros. Clock clk, synchronous reset rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every edge outside reset.
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/cdll_pkg.sv
// ----------------------------------------------------------------------------
// cdll_pkg
// Types and constants of the circular doubly linked list engine.
// ----------------------------------------------------------------------------
package cdll_pkg;

  localparam int CAPACITY = 16;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int LINK_W   = 2 * SLOT_W;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [1:0] {
    CMD_APPEND   = 2'd0,
    CMD_DELETE   = 2'd1,
    CMD_LIST_FWD = 2'd2,
    CMD_LIST_BWD = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_DELETED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_ELEMENT  = 3'd5
  } stat_t;

  // One link memory word: successor and predecessor slot
  typedef struct packed {
    slot_t nxt;
    slot_t prv;
  } link_t;

  // Free slot search result
  typedef struct packed {
    logic  found;
    slot_t slot;
  } alloc_t;

endpackage

// File: rtl/core/cdll_alloc.sv
// ----------------------------------------------------------------------------
// cdll_alloc
// Lowest free slot finder over the occupancy map.
// ----------------------------------------------------------------------------
module cdll_alloc
  import cdll_pkg::*;
(
  input  logic [CAPACITY-1:0] occ,
  output alloc_t              alloc
);

  always_comb begin
    alloc = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!occ[i]) begin
        alloc.found = 1'b1;
        alloc.slot  = SLOT_W'(i);
      end
    end
  end

endmodule

// File: rtl/core/cdll_ram.sv
// ----------------------------------------------------------------------------
// cdll_ram
// Simple dual port RAM: one write port, one registered read port with enable.
// ----------------------------------------------------------------------------
module cdll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/circular_doubly_linked_list.sv
// ----------------------------------------------------------------------------
// circular_doubly_linked_list
// List engine: values and links live in two RAMs, walked one entry a cycle;
//   a listing walks only while the output is not stalled. Append writes the
//   new slot, then relinks tail and head unless the list was empty; delete
//   walks from the head to the match, then relinks; a listing gives one result
//   per entry; an empty list or a full append answers with a status result.
// One item at a time; the walk is bound by the RAM read. Reset: synchronous,
//   active low; list empty, RAM contents left as they are.
`include "assert_macros.svh"

module circular_doubly_linked_list
  import cdll_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // input items
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_cmd,
  input  logic signed [DATA_W-1:0] in_value,
  // result items
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [2:0]               out_status,
  output logic signed [DATA_W-1:0] out_item,
  output logic                     out_last
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_NEW,   // write new slot, read tail link
    S_INS_WT,    // tail.next = new
    S_INS_RH,    // read head link
    S_INS_WH,    // head.prev = new
    S_DEL_CMP,   // compare walked entry
    S_DEL_WP,    // prev.next = next
    S_DEL_RN,    // read next link
    S_DEL_WN,    // next.prev = prev
    S_LIST,      // emit walked entries
    S_RESP       // single status result
  } state_t;

  // control state
  state_t              state_r, state_nxt;
  logic [CAPACITY-1:0] occ_r, occ_nxt;
  slot_t               head_r, head_nxt;
  slot_t               tail_r, tail_nxt;   // mirrors prev of head
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;

  // working registers
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic                     bwd_r, bwd_nxt;
  slot_t                    slot_r, slot_nxt;  // new slot, or walk position
  slot_t                    idx_r, idx_nxt;    // entries visited so far
  slot_t                    p_r, p_nxt;
  slot_t                    nx_r, nx_nxt;
  stat_t                    stat_r, stat_nxt;

  // output payload
  stat_t                    out_status_r, out_status_nxt;
  logic signed [DATA_W-1:0] out_item_r, out_item_nxt;
  logic                     out_last_r, out_last_nxt;

  // RAM ports; value and link RAM share the read address
  logic                     rd_en;
  slot_t                    rd_addr;
  logic                     v_we;
  logic signed [DATA_W-1:0] v_rdata;
  logic                     l_we;
  slot_t                    l_waddr;
  link_t                    l_wdata;
  link_t                    l_rdata;

  alloc_t alloc;
  logic   out_free;
  logic   is_last;

  cdll_alloc u_alloc (
    .occ   (occ_r),
    .alloc (alloc)
  );

  cdll_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_val_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (slot_r),
    .wdata (val_r),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (v_rdata)
  );

  cdll_ram #(
    .WIDTH (LINK_W),
    .DEPTH (CAPACITY)
  ) u_link_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (l_rdata)
  );

  // the output register can take a result this cycle
  assign out_free = !out_valid_r || !out_stall;
  // entry under the walk is the final one of the list
  assign is_last  = (CNT_W'(idx_r) + CNT_W'(1)) == count_r;

  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    val_nxt        = val_r;
    bwd_nxt        = bwd_r;
    slot_nxt       = slot_r;
    idx_nxt        = idx_r;
    p_nxt          = p_r;
    nx_nxt         = nx_r;
    stat_nxt       = stat_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_item_nxt   = out_item_r;
    out_last_nxt   = out_last_r;
    rd_en          = 1'b0;
    rd_addr        = slot_r;
    v_we           = 1'b0;
    l_we           = 1'b0;
    l_waddr        = slot_r;
    l_wdata        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          val_nxt = in_value;
          bwd_nxt = (cmd_t'(in_cmd) == CMD_LIST_BWD);
          idx_nxt = '0;
          case (cmd_t'(in_cmd)) inside
            CMD_APPEND: begin
              if (count_r == CNT_W'(CAPACITY) || !alloc.found) begin
                stat_nxt  = ST_FULL;
                state_nxt = S_RESP;
              end else begin
                slot_nxt  = alloc.slot;
                state_nxt = S_INS_NEW;
              end
            end
            CMD_DELETE: begin
              if (count_r == '0) begin
                stat_nxt  = ST_NOTFOUND;
                state_nxt = S_RESP;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = head_r;
                slot_nxt  = head_r;
                state_nxt = S_DEL_CMP;
              end
            end
            CMD_LIST_FWD, CMD_LIST_BWD: begin
              if (count_r == '0) begin
                stat_nxt  = ST_EMPTY;
                state_nxt = S_RESP;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = (cmd_t'(in_cmd) == CMD_LIST_BWD) ? tail_r : head_r;
                state_nxt = S_LIST;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_INS_NEW: begin
        v_we    = 1'b1;
        l_we    = 1'b1;
        l_waddr = slot_r;
        if (count_r == '0) begin
          // first entry links to itself
          l_wdata.nxt  = slot_r;
          l_wdata.prv  = slot_r;
          head_nxt     = slot_r;
          tail_nxt     = slot_r;
          occ_nxt[slot_r] = 1'b1;
          count_nxt    = count_r + CNT_W'(1);
          stat_nxt     = ST_INSERTED;
          state_nxt    = S_RESP;
        end else begin
          l_wdata.nxt = head_r;
          l_wdata.prv = tail_r;
          rd_en       = 1'b1;
          rd_addr     = tail_r;
          state_nxt   = S_INS_WT;
        end
      end

      S_INS_WT: begin
        l_we        = 1'b1;
        l_waddr     = tail_r;
        l_wdata.nxt = slot_r;
        l_wdata.prv = l_rdata.prv;
        state_nxt   = S_INS_RH;
      end

      S_INS_RH: begin
        // read after the tail write; head may be the same slot
        rd_en     = 1'b1;
        rd_addr   = head_r;
        state_nxt = S_INS_WH;
      end

      S_INS_WH: begin
        l_we        = 1'b1;
        l_waddr     = head_r;
        l_wdata.nxt = l_rdata.nxt;
        l_wdata.prv = slot_r;
        tail_nxt    = slot_r;
        occ_nxt[slot_r] = 1'b1;
        count_nxt   = count_r + CNT_W'(1);
        stat_nxt    = ST_INSERTED;
        state_nxt   = S_RESP;
      end

      S_DEL_CMP: begin
        if (v_rdata == val_r) begin
          if (count_r == CNT_W'(1)) begin
            head_nxt        = '0;
            occ_nxt[slot_r] = 1'b0;
            count_nxt       = count_r - CNT_W'(1);
            stat_nxt        = ST_DELETED;
            state_nxt       = S_RESP;
          end else begin
            p_nxt     = l_rdata.prv;
            nx_nxt    = l_rdata.nxt;
            rd_en     = 1'b1;
            rd_addr   = l_rdata.prv;
            state_nxt = S_DEL_WP;
          end
        end else if (is_last) begin
          stat_nxt  = ST_NOTFOUND;
          state_nxt = S_RESP;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = l_rdata.nxt;
          slot_nxt = l_rdata.nxt;
          idx_nxt  = idx_r + SLOT_W'(1);
        end
      end

      S_DEL_WP: begin
        l_we        = 1'b1;
        l_waddr     = p_r;
        l_wdata.nxt = nx_r;
        l_wdata.prv = l_rdata.prv;
        state_nxt   = S_DEL_RN;
      end

      S_DEL_RN: begin
        // two-entry list: prev and next are one slot, read sees the new word
        rd_en     = 1'b1;
        rd_addr   = nx_r;
        state_nxt = S_DEL_WN;
      end

      S_DEL_WN: begin
        l_we        = 1'b1;
        l_waddr     = nx_r;
        l_wdata.nxt = l_rdata.nxt;
        l_wdata.prv = p_r;
        if (slot_r == head_r) begin
          head_nxt = nx_r;
        end
        if (slot_r == tail_r) begin
          tail_nxt = p_r;
        end
        occ_nxt[slot_r] = 1'b0;
        count_nxt       = count_r - CNT_W'(1);
        stat_nxt        = ST_DELETED;
        state_nxt       = S_RESP;
      end

      S_LIST: begin
        // RAM read data holds while the output is stalled
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_ELEMENT;
          out_item_nxt   = v_rdata;
          out_last_nxt   = is_last;
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = bwd_r ? l_rdata.prv : l_rdata.nxt;
            idx_nxt = idx_r + SLOT_W'(1);
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stat_r;
          out_item_nxt   = val_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      occ_r        <= occ_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
      val_r        <= val_nxt;
      bwd_r        <= bwd_nxt;
      slot_r       <= slot_nxt;
      idx_r        <= idx_nxt;
      p_r          <= p_nxt;
      nx_r         <= nx_nxt;
      stat_r       <= stat_nxt;
      out_status_r <= out_status_nxt;
      out_item_r   <= out_item_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_item   = out_item_r;
  assign out_last   = out_last_r;

  // occupancy map and entry count agree
  `ASSERT_ALWAYS(a_count_occ, $countones(occ_r) == count_r)
  // an emptied list parks the head at slot zero
  `ASSERT_IMPLY(a_empty_head, count_r == '0, head_r == '0)
  // a non-empty list has its head in an occupied slot
  `ASSERT_IMPLY(a_head_occ, count_r != '0, occ_r[head_r])
  // listings never touch the RAMs' write ports
  `ASSERT_IMPLY(a_list_ro, state_r == S_LIST, !v_we && !l_we)

endmodule
